// ===== rtl/core/plob_pkg.sv =====
// Shared types and constants for the price-level order book.
// Holds request codes, cell control struct and default widths.
// Depends on nothing.
package plob_pkg;

  localparam int DEF_LEVELS     = 64;
  localparam int DEF_PRICE_BITS = 32;
  localparam int DEF_QTY_BITS   = 32;
  localparam int REQ_BITS       = 3;
  localparam int DEPTH_BITS     = 7;
  localparam int IMB_BITS       = 16;
  localparam int FRAC_BITS      = 15;

  localparam logic [REQ_BITS-1:0] REQ_SET   = 3'd0;
  localparam logic [REQ_BITS-1:0] REQ_CLEAR = 3'd1;
  localparam logic [REQ_BITS-1:0] REQ_VWAP  = 3'd2;
  localparam logic [REQ_BITS-1:0] REQ_IMB   = 3'd3;
  localparam logic [REQ_BITS-1:0] REQ_READ  = 3'd4;

  // Command applied to a whole side of the book.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_SET,
    OP_CLEAR,
    OP_ROT
  } side_op_t;

  // Broadcast control seen by every cell of one side.
  typedef struct packed {
    side_op_t op;
    logic     qty_zero;
    logic     any_match;
  } cell_ctl_t;

endpackage

// ===== rtl/core/plob_cell.sv =====
// One price level of a sorted side: holds price and quantity.
// Shifts toward either neighbor on insert, delete or rotation.
// Depends on plob_pkg.
module plob_cell import plob_pkg::*; #(
  parameter int PW     = DEF_PRICE_BITS,
  parameter int QW     = DEF_QTY_BITS,
  parameter int CW     = 7,
  parameter int IDX    = 0,
  parameter bit IS_ASK = 1'b0
) (
  input  logic          clk,
  input  cell_ctl_t     ctl,
  input  logic [PW-1:0] new_price,
  input  logic [QW-1:0] new_qty,
  input  logic [CW-1:0] count,
  input  logic          prev_ahead,
  input  logic [PW-1:0] prev_price,
  input  logic [QW-1:0] prev_qty,
  input  logic [PW-1:0] next_price,
  input  logic [QW-1:0] next_qty,
  output logic [PW-1:0] price,
  output logic [QW-1:0] qty,
  output logic          match,
  output logic          ahead
);

  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic [PW-1:0] price_r;
  logic [QW-1:0] qty_r;
  logic          occ;

  // Compare the broadcast price against the held level
  always_comb begin
    occ   = IDX_C < count;
    match = occ && (price_r == new_price);
    ahead = occ && (IS_ASK ? (new_price < price_r) : (new_price > price_r));
  end

  // Update the level
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_SET: begin
        if (ctl.any_match) begin
          if (ctl.qty_zero) begin
            if (match || ahead) begin
              price_r <= next_price;
              qty_r   <= next_qty;
            end
          end else if (match) begin
            qty_r <= new_qty;
          end
        end else if (!ctl.qty_zero) begin
          if (prev_ahead) begin
            price_r <= prev_price;
            qty_r   <= prev_qty;
          end else if (ahead || (IDX_C == count)) begin
            price_r <= new_price;
            qty_r   <= new_qty;
          end
        end
      end
      OP_ROT: begin
        price_r <= next_price;
        qty_r   <= next_qty;
      end
      default: begin
      end
    endcase
  end

  assign price = price_r;
  assign qty   = qty_r;

endmodule

// ===== rtl/core/plob_side.sv =====
// One side of the book: a chain of level cells kept in rank order plus
// the level count. Depends on plob_pkg and plob_cell.
module plob_side import plob_pkg::*; #(
  parameter int LEVELS = DEF_LEVELS,
  parameter int PW     = DEF_PRICE_BITS,
  parameter int QW     = DEF_QTY_BITS,
  parameter bit IS_ASK = 1'b0,
  parameter int CW     = $clog2(LEVELS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  side_op_t      op,
  input  logic [PW-1:0] new_price,
  input  logic [QW-1:0] new_qty,
  output logic [PW-1:0] head_price,
  output logic [QW-1:0] head_qty,
  output logic [CW-1:0] count
);

  localparam logic [CW-1:0] LEVELS_C = CW'(LEVELS);

  logic [PW-1:0]     price_w [LEVELS];
  logic [QW-1:0]     qty_w   [LEVELS];
  logic [LEVELS-1:0] match_w;
  logic [LEVELS-1:0] ahead_w;
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     cnt_nxt;
  cell_ctl_t         ctl;

  assign ctl.op        = op;
  assign ctl.qty_zero  = (new_qty == '0);
  assign ctl.any_match = |match_w;

  // Chain of cells; the last cell wraps to the first for rotation
  for (genvar i = 0; i < LEVELS; i++) begin : g_cell
    logic          pa;
    logic [PW-1:0] pp;
    logic [QW-1:0] pq;
    logic [PW-1:0] np;
    logic [QW-1:0] nq;
    if (i == 0) begin : g_first
      assign pa = 1'b0;
      assign pp = '0;
      assign pq = '0;
    end else begin : g_mid
      assign pa = ahead_w[i-1];
      assign pp = price_w[i-1];
      assign pq = qty_w[i-1];
    end
    if (i == LEVELS - 1) begin : g_last
      assign np = price_w[0];
      assign nq = qty_w[0];
    end else begin : g_inner
      assign np = price_w[i+1];
      assign nq = qty_w[i+1];
    end
    plob_cell #(
      .PW(PW), .QW(QW), .CW(CW), .IDX(i), .IS_ASK(IS_ASK)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .new_price (new_price),
      .new_qty   (new_qty),
      .count     (cnt_r),
      .prev_ahead(pa),
      .prev_price(pp),
      .prev_qty  (pq),
      .next_price(np),
      .next_qty  (nq),
      .price     (price_w[i]),
      .qty       (qty_w[i]),
      .match     (match_w[i]),
      .ahead     (ahead_w[i])
    );
  end

  // Track the level count
  always_comb begin
    cnt_nxt = cnt_r;
    case (op)
      OP_SET: begin
        if (ctl.any_match) begin
          if (ctl.qty_zero) begin
            cnt_nxt = cnt_r - 1'b1;
          end
        end else if (!ctl.qty_zero && (cnt_r < LEVELS_C)) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      OP_CLEAR: cnt_nxt = '0;
      default:  cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign head_price = price_w[0];
  assign head_qty   = qty_w[0];
  assign count      = cnt_r;

endmodule

// ===== rtl/core/plob_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the fill
// price and imbalance paths. Depends on plob_pkg.
module plob_div import plob_pkg::*; #(
  parameter int NW = 64,
  parameter int DW = 33
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          run,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int NCW = $clog2(NW + 1);
  localparam logic [NCW-1:0] LAST = NCW'(NW - 1);

  logic [NW-1:0]  num_r;
  logic [DW-1:0]  den_r;
  logic [DW-1:0]  rem_r;
  logic [NCW-1:0] cnt_r;
  logic           run_r;
  logic           done_r;
  logic [DW:0]    rem_sh;
  logic           qbit;
  logic [DW:0]    rem_sub;

  // Trial subtract of the shifted remainder
  always_comb begin
    rem_sh  = {rem_r, num_r[NW-1]};
    rem_sub = rem_sh - {1'b0, den_r};
    qbit    = rem_sh >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        num_r <= num;
        den_r <= den;
        rem_r <= '0;
      end else if (run_r) begin
        num_r <= {num_r[NW-2:0], qbit};
        rem_r <= qbit ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign run  = run_r;
  assign done = done_r;
  assign quo  = num_r;

endmodule

// ===== rtl/core/price_level_order_book_unit.sv =====
// Price-level order book. A set-level or clear-side transaction updates the
// cell chain of the addressed side, which inserts, replaces or deletes, and the
// top of book is then reported through the output register. Reads, imbalance
// and fill-price queries rotate both chains once past the head cell; imbalance
// and fill-price queries then divide in the one-bit-per-cycle divider unless
// the divisor is zero. NW, the dividend width of that divider, is
// PRICE_BITS+QTY_BITS, at least QTY_BITS+15. Other request codes leave the
// book alone. The next transaction is taken while the previous result waits
// in the output register.
// Depends on plob_pkg, plob_side, plob_cell and plob_div.
module price_level_order_book_unit import plob_pkg::*; #(
  parameter int LEVELS     = DEF_LEVELS,
  parameter int PRICE_BITS = DEF_PRICE_BITS,
  parameter int QTY_BITS   = DEF_QTY_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [REQ_BITS-1:0]   in_req_type,
  input  logic                  in_side,
  input  logic [PRICE_BITS-1:0] in_price,
  input  logic [QTY_BITS-1:0]   in_quantity,
  input  logic [DEPTH_BITS-1:0] in_depth_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PRICE_BITS-1:0] out_bid_price,
  output logic [PRICE_BITS-1:0] out_ask_price,
  output logic [QTY_BITS-1:0]   out_bid_qty,
  output logic [QTY_BITS-1:0]   out_ask_qty,
  output logic [PRICE_BITS-1:0] out_mid,
  output logic signed [PRICE_BITS:0] out_spread,
  output logic                  out_book_ok,
  output logic [PRICE_BITS-1:0] out_query_price,
  output logic [QTY_BITS-1:0]   out_query_qty,
  output logic [QTY_BITS-1:0]   out_query_aux_qty,
  output logic signed [IMB_BITS-1:0] out_imbalance_q15,
  output logic                  out_query_found
);

  localparam int PW   = PRICE_BITS;
  localparam int QW   = QTY_BITS;
  localparam int CW   = $clog2(LEVELS + 1);
  localparam int KW   = $clog2(LEVELS);
  localparam int NW   = (PW + QW > QW + FRAC_BITS) ? (PW + QW) : (QW + FRAC_BITS);
  localparam int DW   = QW + 1;
  localparam int CMPW = ((CW > DEPTH_BITS) ? CW : DEPTH_BITS) + 1;
  localparam logic [KW-1:0] K_LAST = KW'(LEVELS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DIV,
    S_FIN
  } state_t;

  state_t                state_r;
  logic [REQ_BITS-1:0]   req_r;
  logic                  side_r;
  logic [DEPTH_BITS-1:0] depth_r;
  logic [KW-1:0]         k_r;
  logic                  drain_r;

  logic [QW-1:0]    rem_r;
  logic [QW-1:0]    filled_r;
  logic [PW-1:0]    pb_price_r;
  logic [QW-1:0]    pb_fill_r;
  logic             vb_r;
  logic [PW+QW-1:0] prod_r;
  logic             vc_r;
  logic [PW+QW-1:0] acc_r;
  logic [QW-1:0]    bv_r;
  logic [QW-1:0]    av_r;

  logic [PW-1:0]       qp_r;
  logic [QW-1:0]       qq_r;
  logic                found_r;

  logic                out_valid_r;
  logic [PW-1:0]       bb_r;
  logic [PW-1:0]       ba_r;
  logic [QW-1:0]       bbq_r;
  logic [QW-1:0]       baq_r;
  logic [PW-1:0]       mid_r;
  logic [PW:0]         spr_r;
  logic                ok_r;
  logic [PW-1:0]       oqp_r;
  logic [QW-1:0]       oqq_r;
  logic [QW-1:0]       oqa_r;
  logic [IMB_BITS-1:0] imb_r;
  logic                ofound_r;

  logic          accept;
  side_op_t      bid_op;
  side_op_t      ask_op;
  logic [PW-1:0] bid_hp;
  logic [QW-1:0] bid_hq;
  logic [CW-1:0] bid_cnt;
  logic [PW-1:0] ask_hp;
  logic [QW-1:0] ask_hq;
  logic [CW-1:0] ask_cnt;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  // Issue side commands: updates on acceptance, rotation while scanning
  always_comb begin
    bid_op = OP_HOLD;
    ask_op = OP_HOLD;
    if (state_r == S_SCAN) begin
      bid_op = OP_ROT;
      ask_op = OP_ROT;
    end else if (accept) begin
      if (in_req_type == REQ_SET) begin
        if (in_side) ask_op = OP_SET;
        else bid_op = OP_SET;
      end else if (in_req_type == REQ_CLEAR) begin
        if (in_side) ask_op = OP_CLEAR;
        else bid_op = OP_CLEAR;
      end
    end
  end

  plob_side #(.LEVELS(LEVELS), .PW(PW), .QW(QW), .IS_ASK(1'b0)) u_bid (
    .clk(clk), .rst_n(rst_n), .op(bid_op), .new_price(in_price),
    .new_qty(in_quantity), .head_price(bid_hp), .head_qty(bid_hq), .count(bid_cnt)
  );

  plob_side #(.LEVELS(LEVELS), .PW(PW), .QW(QW), .IS_ASK(1'b1)) u_ask (
    .clk(clk), .rst_n(rst_n), .op(ask_op), .new_price(in_price),
    .new_qty(in_quantity), .head_price(ask_hp), .head_qty(ask_hq), .count(ask_cnt)
  );

  // Head of the chosen side during the scan
  logic [PW-1:0] h_price;
  logic [QW-1:0] h_qty;
  logic          k_in_side;
  logic          k_in_bid;
  logic          k_in_ask;
  logic          k_lt_depth;
  logic          k_eq_depth;
  logic [QW-1:0] fill_a;
  logic          va;
  logic [QW:0]   bsum;
  logic [QW:0]   asum;

  always_comb begin
    h_price    = side_r ? ask_hp : bid_hp;
    h_qty      = side_r ? ask_hq : bid_hq;
    k_in_bid   = CMPW'(k_r) < CMPW'(bid_cnt);
    k_in_ask   = CMPW'(k_r) < CMPW'(ask_cnt);
    k_in_side  = side_r ? k_in_ask : k_in_bid;
    k_lt_depth = CMPW'(k_r) < CMPW'(depth_r);
    k_eq_depth = CMPW'(k_r) == CMPW'(depth_r);
    fill_a     = (h_qty < rem_r) ? h_qty : rem_r;
    va         = (state_r == S_SCAN) && (req_r == REQ_VWAP) && k_in_side &&
                 (rem_r != '0);
    bsum       = {1'b0, bv_r} + {1'b0, bid_hq};
    asum       = {1'b0, av_r} + {1'b0, ask_hq};
  end

  // Divider operands
  logic [DW-1:0] total;
  logic [QW-1:0] mag;
  logic          bid_ge;
  logic [NW-1:0] div_num;
  logic [DW-1:0] div_den;
  logic          div_start;
  logic          div_run;
  logic          div_done;
  logic [NW-1:0] div_quo;

  always_comb begin
    total     = {1'b0, bv_r} + {1'b0, av_r};
    bid_ge    = bv_r >= av_r;
    mag       = bid_ge ? (bv_r - av_r) : (av_r - bv_r);
    div_num   = (req_r == REQ_VWAP) ? NW'(acc_r) : NW'({mag, {FRAC_BITS{1'b0}}});
    div_den   = (req_r == REQ_VWAP) ? DW'(filled_r) : total;
    div_start = (state_r == S_DIV) && !div_run && !div_done &&
                !((req_r == REQ_IMB) && (total == '0));
  end

  plob_div #(.NW(NW), .DW(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .run(div_run), .done(div_done), .quo(div_quo)
  );

  // Top of book and imbalance result
  logic          bid_ne;
  logic          ask_ne;
  logic [PW-1:0] bb;
  logic [PW-1:0] ba;
  logic [PW:0]   psum;
  logic [IMB_BITS-1:0] imb_val;
  logic          load_out;

  always_comb begin
    bid_ne   = bid_cnt != '0;
    ask_ne   = ask_cnt != '0;
    bb       = bid_ne ? bid_hp : '0;
    ba       = ask_ne ? ask_hp : '0;
    psum     = {1'b0, bb} + {1'b0, ba};
    if (total == '0) begin
      imb_val = '0;
    end else if (bid_ge) begin
      imb_val = (|div_quo[NW-1:FRAC_BITS]) ? {1'b0, {FRAC_BITS{1'b1}}} :
                {1'b0, div_quo[FRAC_BITS-1:0]};
    end else begin
      imb_val = -div_quo[IMB_BITS-1:0];
    end
    load_out = (state_r == S_FIN) && (!out_valid_r || !out_stall);
  end

  // Sequencer, query datapath and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      k_r         <= '0;
      drain_r     <= 1'b0;
    end else begin
      // advance the fill-price pipeline
      vb_r       <= va;
      pb_price_r <= h_price;
      pb_fill_r  <= fill_a;
      vc_r       <= vb_r;
      prod_r     <= pb_price_r * pb_fill_r;
      if (vc_r) begin
        acc_r <= acc_r + prod_r;
      end
      if (va) begin
        rem_r    <= rem_r - fill_a;
        filled_r <= filled_r + fill_a;
      end

      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            req_r    <= in_req_type;
            side_r   <= in_side;
            depth_r  <= in_depth_index;
            rem_r    <= in_quantity;
            filled_r <= '0;
            acc_r    <= '0;
            bv_r     <= '0;
            av_r     <= '0;
            qp_r     <= '0;
            qq_r     <= '0;
            found_r  <= 1'b0;
            k_r      <= '0;
            drain_r  <= 1'b0;
            if ((in_req_type == REQ_VWAP) || (in_req_type == REQ_IMB) ||
                (in_req_type == REQ_READ)) begin
              state_r <= S_SCAN;
            end else begin
              state_r <= S_FIN;
            end
          end
        end
        S_SCAN: begin
          if ((req_r == REQ_READ) && k_eq_depth && k_in_side) begin
            qp_r    <= h_price;
            qq_r    <= h_qty;
            found_r <= 1'b1;
          end
          if ((req_r == REQ_IMB) && k_lt_depth) begin
            if (k_in_bid) bv_r <= bsum[QW] ? '1 : bsum[QW-1:0];
            if (k_in_ask) av_r <= asum[QW] ? '1 : asum[QW-1:0];
          end
          k_r <= k_r + 1'b1;
          if (k_r == K_LAST) begin
            if (req_r == REQ_VWAP) state_r <= S_DRAIN;
            else if (req_r == REQ_IMB) state_r <= S_DIV;
            else state_r <= S_FIN;
          end
        end
        S_DRAIN: begin
          drain_r <= 1'b1;
          if (drain_r) begin
            state_r <= (filled_r != '0) ? S_DIV : S_FIN;
          end
        end
        S_DIV: begin
          if ((req_r == REQ_IMB) && (total == '0)) begin
            state_r <= S_FIN;
          end else if (div_done) begin
            if (req_r == REQ_VWAP) begin
              qp_r    <= div_quo[PW-1:0];
              found_r <= 1'b1;
            end
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (load_out) begin
            bb_r     <= bb;
            ba_r     <= ba;
            bbq_r    <= bid_ne ? bid_hq : '0;
            baq_r    <= ask_ne ? ask_hq : '0;
            mid_r    <= (bid_ne && ask_ne) ? psum[PW:1] : '0;
            spr_r    <= (bid_ne && ask_ne) ? ({1'b0, ba} - {1'b0, bb}) : '0;
            ok_r     <= bid_ne && ask_ne && (bb < ba);
            oqp_r    <= qp_r;
            oqq_r    <= (req_r == REQ_IMB) ? bv_r : qq_r;
            oqa_r    <= (req_r == REQ_IMB) ? av_r : '0;
            imb_r    <= (req_r == REQ_IMB) ? imb_val : '0;
            ofound_r <= found_r;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_bid_price     = bb_r;
  assign out_ask_price     = ba_r;
  assign out_bid_qty       = bbq_r;
  assign out_ask_qty       = baq_r;
  assign out_mid           = mid_r;
  assign out_spread        = spr_r;
  assign out_book_ok       = ok_r;
  assign out_query_price   = oqp_r;
  assign out_query_qty     = oqq_r;
  assign out_query_aux_qty = oqa_r;
  assign out_imbalance_q15 = imb_r;
  assign out_query_found   = ofound_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (bid_cnt <= CW'(LEVELS)) && (ask_cnt <= CW'(LEVELS)))
    else $error("level count above capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("transaction accepted without going busy");

  a_ok_uncrossed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_book_ok |-> (out_bid_price < out_ask_price))
    else $error("book flagged ok while crossed");

  a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_run |-> (state_r == S_DIV))
    else $error("divider running outside divide phase");
`endif

endmodule

// ===== dv/tb_price_level_order_book_unit.sv =====
// Self-checking testbench for the price-level order book unit.
// A book model inside a small scoreboard class predicts each result.
// Depends on plob_pkg and price_level_order_book_unit.
`timescale 1ns / 1ps

module tb_price_level_order_book_unit;
  import plob_pkg::*;

  localparam int NLEV = DEF_LEVELS;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [31:0] bid_price, ask_price, bid_qty, ask_qty, mid;
    logic signed [32:0] spread;
    logic book_ok;
    logic [31:0] query_price, query_qty, query_aux_qty;
    logic signed [15:0] imbalance_q15;
    logic query_found;
  } book_result_t;

  // Book model and queue of pending results
  class book_scoreboard;
    logic [31:0] lvl_px [2][NLEV];
    logic [31:0] lvl_qty[2][NLEV];
    int count[2];
    book_result_t pending[$];
    int errors;

    function void reset_book();
      count[0] = 0;
      count[1] = 0;
      errors = 0;
    endfunction

    function bit ranks_ahead(bit s, logic [31:0] a, logic [31:0] b);
      return s ? (a < b) : (a > b);
    endfunction

    function void set_level(bit s, logic [31:0] px, logic [31:0] q);
      int n, pos, last;
      n = count[s];
      pos = n;
      for (int i = 0; i < n; i++) begin
        if (lvl_px[s][i] == px) begin
          if (q != 0) lvl_qty[s][i] = q;
          else begin
            for (int j = i; j + 1 < n; j++) begin
              lvl_px[s][j] = lvl_px[s][j+1];
              lvl_qty[s][j] = lvl_qty[s][j+1];
            end
            count[s] = n - 1;
          end
          return;
        end
      end
      if (q == 0) return;
      for (int i = 0; i < n; i++)
        if (ranks_ahead(s, px, lvl_px[s][i])) begin
          pos = i;
          break;
        end
      if (pos >= NLEV) return;
      last = (n < NLEV) ? n : NLEV - 1;
      for (int i = last; i > pos; i--) begin
        lvl_px[s][i] = lvl_px[s][i-1];
        lvl_qty[s][i] = lvl_qty[s][i-1];
      end
      lvl_px[s][pos] = px;
      lvl_qty[s][pos] = q;
      count[s] = last + 1;
    endfunction

    function logic [31:0] volume(bit s, int depth);
      logic [33:0] sum;
      sum = '0;
      for (int i = 0; i < count[s] && i < depth; i++) begin
        sum += 34'(lvl_qty[s][i]);
        if (sum > 34'hFFFF_FFFF) sum = 34'hFFFF_FFFF;
      end
      return sum[31:0];
    endfunction

    // Apply one accepted transaction and queue its expected result
    function void note_request(logic [2:0] req, bit s, logic [31:0] px,
                               logic [31:0] q, logic [6:0] depth);
      book_result_t r;
      logic [127:0] notional;
      logic [63:0] filled, rest, fill;
      logic [33:0] total, mag;
      logic [48:0] ratio;
      r = '{default: 0};
      case (req)
        REQ_SET: set_level(s, px, q);
        REQ_CLEAR: count[s] = 0;
        REQ_VWAP: begin
          notional = 0;
          filled = 0;
          rest = 64'(q);
          for (int i = 0; i < count[s] && rest != 0; i++) begin
            fill = (64'(lvl_qty[s][i]) < rest) ? 64'(lvl_qty[s][i]) : rest;
            notional += 128'(lvl_px[s][i]) * 128'(fill);
            filled += fill;
            rest -= fill;
          end
          if (filled != 0) begin
            r.query_price = 32'(notional / 128'(filled));
            r.query_found = 1;
          end
        end
        REQ_IMB: begin
          r.query_qty = volume(1'b0, int'(depth));
          r.query_aux_qty = volume(1'b1, int'(depth));
          total = 34'(r.query_qty) + 34'(r.query_aux_qty);
          if (total != 0) begin
            mag = (r.query_qty >= r.query_aux_qty) ? 34'(r.query_qty - r.query_aux_qty)
                                                   : 34'(r.query_aux_qty - r.query_qty);
            ratio = (49'(mag) << 15) / 49'(total);
            if (r.query_qty >= r.query_aux_qty)
              r.imbalance_q15 = (ratio > 32767) ? 16'sd32767 : 16'(ratio);
            else r.imbalance_q15 = 16'(-ratio);
          end
        end
        REQ_READ: begin
          if (depth < count[s]) begin
            r.query_price = lvl_px[s][depth];
            r.query_qty = lvl_qty[s][depth];
            r.query_found = 1;
          end
        end
        default: ;
      endcase
      if (count[0] != 0) begin
        r.bid_price = lvl_px[0][0];
        r.bid_qty = lvl_qty[0][0];
      end
      if (count[1] != 0) begin
        r.ask_price = lvl_px[1][0];
        r.ask_qty = lvl_qty[1][0];
      end
      if (count[0] != 0 && count[1] != 0) begin
        r.mid = 32'((33'(r.bid_price) + 33'(r.ask_price)) >> 1);
        r.spread = 33'(r.ask_price) - 33'(r.bid_price);
        r.book_ok = r.bid_price < r.ask_price;
      end
      pending.push_back(r);
    endfunction

    function void check_result(book_result_t a);
      book_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.bid_price !== e.bid_price) begin
        $error("bid_price exp %0d got %0d", e.bid_price, a.bid_price); errors++; end
      if (a.ask_price !== e.ask_price) begin
        $error("ask_price exp %0d got %0d", e.ask_price, a.ask_price); errors++; end
      if (a.bid_qty !== e.bid_qty) begin
        $error("bid_qty exp %0d got %0d", e.bid_qty, a.bid_qty); errors++; end
      if (a.ask_qty !== e.ask_qty) begin
        $error("ask_qty exp %0d got %0d", e.ask_qty, a.ask_qty); errors++; end
      if (a.mid !== e.mid) begin
        $error("mid exp %0d got %0d", e.mid, a.mid); errors++; end
      if (a.spread !== e.spread) begin
        $error("spread exp %0d got %0d", e.spread, a.spread); errors++; end
      if (a.book_ok !== e.book_ok) begin
        $error("book_ok exp %0d got %0d", e.book_ok, a.book_ok); errors++; end
      if (a.query_price !== e.query_price) begin
        $error("query_price exp %0d got %0d", e.query_price, a.query_price); errors++; end
      if (a.query_qty !== e.query_qty) begin
        $error("query_qty exp %0d got %0d", e.query_qty, a.query_qty); errors++; end
      if (a.query_aux_qty !== e.query_aux_qty) begin
        $error("query_aux_qty exp %0d got %0d", e.query_aux_qty, a.query_aux_qty);
        errors++;
      end
      if (a.imbalance_q15 !== e.imbalance_q15) begin
        $error("imbalance_q15 exp %0d got %0d", e.imbalance_q15, a.imbalance_q15);
        errors++;
      end
      if (a.query_found !== e.query_found) begin
        $error("query_found exp %0d got %0d", e.query_found, a.query_found); errors++; end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, in_side, out_valid, out_stall;
  logic [REQ_BITS-1:0] in_req_type;
  logic [31:0] in_price, in_quantity;
  logic [DEPTH_BITS-1:0] in_depth_index;
  logic [31:0] out_bid_price, out_ask_price, out_bid_qty, out_ask_qty;
  logic [31:0] out_mid, out_query_price, out_query_qty, out_query_aux_qty;
  logic signed [32:0] out_spread;
  logic signed [15:0] out_imbalance_q15;
  logic out_book_ok, out_query_found;

  book_scoreboard book_sb;
  int idle_cycles = 0;
  int stall_left;
  logic [31:0] price_pool[8];

  price_level_order_book_unit u_top (.*);

  // Generate clock
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Drive one transaction and hold it until accepted
  task automatic send_request(logic [2:0] req, int s, logic [31:0] px,
                              logic [31:0] q, int depth);
    int g;
    logic s_b;
    logic [6:0] d_b;
    s_b = 1'(s);
    d_b = 7'(depth);
    g = gap_len();
    repeat (g) @(negedge clk);
    in_valid = 1;
    in_req_type = req;
    in_side = s_b;
    in_price = px;
    in_quantity = q;
    in_depth_index = d_b;
    do @(posedge clk); while (in_stall);
    book_sb.note_request(req, s_b, px, q, d_b);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic wait_drained();
    while (book_sb.pending.size() != 0) @(negedge clk);
  endtask

  function logic [31:0] pick_price();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return price_pool[$urandom_range(0, 7)] + $urandom_range(0, 40);
    if (r == 7) return $urandom;
    return (r == 8) ? 32'h0 : 32'hFFFF_FFFF;
  endfunction

  function logic [31:0] pick_qty();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 0;
    if (r < 7) return $urandom_range(1, 1000);
    if (r == 7) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Random receiver stall: mostly short bursts, now and then a long one
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      out_stall <= 1;
      stall_left--;
    end else if ($urandom_range(0, 9) < 7) out_stall <= 0;
    else begin
      out_stall <= 1;
      stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                                : $urandom_range(0, 2);
    end
  end

  // Check results and run the watchdog
  always @(posedge clk) begin
    book_result_t a;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        a.bid_price = out_bid_price;
        a.ask_price = out_ask_price;
        a.bid_qty = out_bid_qty;
        a.ask_qty = out_ask_qty;
        a.mid = out_mid;
        a.spread = out_spread;
        a.book_ok = out_book_ok;
        a.query_price = out_query_price;
        a.query_qty = out_query_qty;
        a.query_aux_qty = out_query_aux_qty;
        a.imbalance_q15 = out_imbalance_q15;
        a.query_found = out_query_found;
        book_sb.check_result(a);
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int n;
    book_sb = new();
    book_sb.reset_book();
    rst_n = 0;
    in_valid = 0;
    in_req_type = REQ_SET;
    in_side = 0;
    in_price = 0;
    in_quantity = 0;
    in_depth_index = 0;
    for (int i = 0; i < 8; i++) price_pool[i] = $urandom_range(50, 200) * 100;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: empty book, extremes, deletes, unused codes
    send_request(REQ_READ, 0, 0, 0, 0);
    send_request(REQ_VWAP, 1, 0, 100, 0);
    send_request(REQ_IMB, 0, 0, 0, 64);
    send_request(REQ_SET, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_request(REQ_SET, 1, 32'h0, 32'hFFFF_FFFF, 0);
    send_request(REQ_IMB, 0, 0, 0, 64);
    send_request(REQ_VWAP, 0, 0, 32'hFFFF_FFFF, 0);
    send_request(REQ_SET, 0, 32'hFFFF_FFFF, 0, 0);
    send_request(REQ_SET, 0, 100, 5, 0);
    send_request(REQ_SET, 0, 100, 7, 0);
    send_request(REQ_SET, 0, 123, 0, 0);
    send_request(REQ_SET, 1, 200, 9, 0);
    send_request(REQ_VWAP, 1, 0, 0, 0);
    send_request(REQ_VWAP, 1, 0, 1000, 0);
    send_request(REQ_READ, 1, 0, 0, 1);
    send_request(REQ_READ, 1, 0, 0, 127);
    send_request(REQ_IMB, 0, 0, 0, 0);
    send_request(REQ_IMB, 1, 0, 0, 127);
    send_request(3'd5, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 127);
    send_request(3'd6, 0, 0, 0, 0);
    send_request(3'd7, 0, 0, 0, 0);
    send_request(REQ_CLEAR, 1, 0, 0, 0);
    send_request(REQ_CLEAR, 0, 0, 0, 0);

    // Fill both sides past capacity so the worst level gets dropped
    for (int i = 0; i < 70; i++) send_request(REQ_SET, 0, 1000 + i * 3, i + 1, 0);
    send_request(REQ_SET, 0, 5, 1, 0);
    for (int i = 0; i < 70; i++) send_request(REQ_SET, 1, 5000 - i * 3, i + 1, 0);
    send_request(REQ_SET, 1, 9000, 1, 0);
    send_request(REQ_READ, 0, 0, 0, 63);
    send_request(REQ_READ, 1, 0, 0, 64);
    send_request(REQ_IMB, 0, 0, 0, 64);

    // Let the book drain once before the random part
    wait_drained();

    // Random mix weighted toward level updates
    n = 0;
    while (n < 1100) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) send_request(REQ_SET, $urandom_range(0, 1), pick_price(), pick_qty(),
                               $urandom_range(0, 127));
      else if (r < 58) send_request(REQ_CLEAR, $urandom_range(0, 1), $urandom, $urandom, 0);
      else if (r < 70) send_request(REQ_VWAP, $urandom_range(0, 1), $urandom,
                                    pick_qty(), $urandom_range(0, 127));
      else if (r < 82) send_request(REQ_IMB, $urandom_range(0, 1), $urandom, $urandom,
                                    $urandom_range(0, 127));
      else if (r < 97) send_request(REQ_READ, $urandom_range(0, 1), $urandom, $urandom,
                                    $urandom_range(0, 127));
      else send_request(3'($urandom_range(5, 7)), $urandom_range(0, 1), $urandom, $urandom,
                        $urandom_range(0, 127));
      n++;
      if (n == 550) wait_drained();
    end

    // Drain and finish
    wait_drained();
    repeat (200) @(negedge clk);
    if (book_sb.errors == 0 && book_sb.pending.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/plob_pkg.sv
rtl/core/plob_cell.sv
rtl/core/plob_side.sv
rtl/core/plob_div.sv
rtl/core/price_level_order_book_unit.sv
dv/tb_price_level_order_book_unit.sv
